[hdl/ecw_pkg.sv]
// shared types, codes and defaults of the euler circuit walker
package ecw_pkg;

    localparam int KIND_W   = 2;
    localparam int VTX_W    = 6;
    localparam int CNT_W    = 11;
    localparam int STATUS_W = 3;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_STACK_DEPTH  = 2048;

    // largest edge count the store accepts, before the stack depth bound
    localparam int EDGE_CAP = 2046;

    // bits of an adjacency row examined per scan cycle
    localparam int SCAN_CW = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_BUILD = 2'd2,
        KIND_POP   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_REJECTED  = 3'd1,
        ST_BUILT     = 3'd2,
        ST_VERTEX    = 3'd3,
        ST_EXHAUSTED = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_CHK,
        S_ADD_B,
        S_B_READ,
        S_B_LOAD,
        S_B_SCAN,
        S_B_DEL,
        S_B_POP_WAIT,
        S_POP_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic done;
        logic found;
    } t_scan_rsp;

endpackage

[hdl/ecw_if.sv]
// valid/ready channel interfaces for commands and responses
interface ecw_cmd_if import ecw_pkg::*; ();
    logic               valid;
    logic               ready;
    t_kind              kind;
    logic [VTX_W-1:0]   vertex_a;
    logic [VTX_W-1:0]   vertex_b;

    modport source (output valid, output kind, output vertex_a, output vertex_b,
                    input ready);
    modport sink   (input valid, input kind, input vertex_a, input vertex_b,
                    output ready);
endinterface

interface ecw_rsp_if import ecw_pkg::*; ();
    logic               valid;
    logic               ready;
    t_status            status;
    logic [VTX_W-1:0]   vertex;
    logic [CNT_W-1:0]   count;

    modport source (output valid, output status, output vertex, output count,
                    input ready);
    modport sink   (input valid, input status, input vertex, input count,
                    output ready);
endinterface

[hdl/ecw_ram.sv]
// generic single write port ram with registered read
module ecw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

[hdl/ecw_scan.sv]
// iterative lowest-set-bit search over one adjacency row
module ecw_scan import ecw_pkg::*; #(
    parameter int NV = DEF_MAX_VERTICES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NV-1:0]         i_row,
    output t_scan_rsp             o_rsp,
    output logic [$clog2(NV)-1:0] o_index
);
    localparam int VW  = $clog2(NV);
    localparam int NCH = (NV + SCAN_CW - 1) / SCAN_CW;
    localparam int CIW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PW  = NCH * SCAN_CW;
    localparam int PIW = $clog2(SCAN_CW);

    logic               r_busy;
    logic [CIW-1:0]     r_cnt;
    logic [PW-1:0]      w_pad;
    logic [SCAN_CW-1:0] w_chunk;
    logic [PIW-1:0]     w_pos;
    logic               w_hit;
    logic               w_last;
    logic [CIW+PIW-1:0] w_idx;

    assign w_pad   = PW'(i_row);
    assign w_chunk = w_pad[r_cnt*SCAN_CW +: SCAN_CW];
    assign w_hit   = |w_chunk;
    assign w_last  = (r_cnt == CIW'(NCH - 1));

    // priority encode, lowest bit wins
    always_comb begin
        w_pos = '0;
        for (int i = SCAN_CW - 1; i >= 0; i--) begin
            if (w_chunk[i]) begin
                w_pos = PIW'(i);
            end
        end
    end

    assign w_idx       = {r_cnt, w_pos};
    assign o_index     = VW'(w_idx);
    assign o_rsp.done  = r_busy && (w_hit || w_last);
    assign o_rsp.found = r_busy && w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (o_rsp.done) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + CIW'(1);
            end
        end
    end
endmodule

[hdl/euler_circuit_walker.sv]
// euler circuit walker top level: adjacency store, stacks and sequencer
//
// usage
//   i_cmd carries one command per transfer: add edge (vertex_a, vertex_b),
//   clear graph, build circuit from vertex_a, or pop the next circuit vertex.
//   o_rsp returns exactly one response per command: status, popped vertex
//   and a count (edge count, circuit length or vertices left).
//   the block works on one command at a time; i_cmd.ready is high only in
//   idle, and stays high while a finished response waits on o_rsp.
// timing
//   add edge is a read-check-write of two adjacency rows. build seeds
//   the walk stack, then per walk step drops the edge, reads the
//   neighbour's row and scans it; per retired vertex it pops the walk
//   stack, rereads the row of the new top and scans it again.
//   the row scanner looks at 8 adjacency bits per cycle, and the single
//   read port of the adjacency ram sets the step length.
// reset
//   synchronous, active low; row valid flops clear at once, so the graph
//   reads empty right after reset with no clearing pass. the stacks hold
//   no reset value; only entries below their tops are ever read.
// stall
//   a response held by a stalled receiver keeps its payload; the next
//   command may be taken meanwhile and its response waits in S_EMIT.
module euler_circuit_walker import ecw_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int STACK_DEPTH  = DEF_STACK_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ecw_cmd_if.sink    i_cmd,
    ecw_rsp_if.source  o_rsp
);
    localparam int NV  = MAX_VERTICES;
    localparam int VW  = $clog2(NV);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int STW = $clog2(STACK_DEPTH + 1);
    localparam int EDGE_LIMIT = (STACK_DEPTH - 1 < EDGE_CAP) ? STACK_DEPTH - 1 : EDGE_CAP;

    // sequencer state and control
    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic [NV-1:0]      r_row_vld, n_row_vld;
    logic               r_rd_vld, n_rd_vld;
    logic [STW-1:0]     r_walk_top, n_walk_top;
    logic [STW-1:0]     r_circ_top, n_circ_top;
    logic [CNT_W-1:0]   r_edges, n_edges;
    logic               r_out_valid, n_out_valid;

    // payload registers
    logic [VTX_W-1:0]   r_a_in, n_a_in;
    logic [VTX_W-1:0]   r_b_in, n_b_in;
    logic [VW-1:0]      r_cur, n_cur;
    logic [VW-1:0]      r_nbr, n_nbr;
    logic [NV-1:0]      r_row, n_row;
    t_status            r_res_status, n_res_status;
    logic [VTX_W-1:0]   r_res_vertex, n_res_vertex;
    logic [CNT_W-1:0]   r_res_count, n_res_count;
    t_status            r_out_status, n_out_status;
    logic [VTX_W-1:0]   r_out_vertex, n_out_vertex;
    logic [CNT_W-1:0]   r_out_count, n_out_count;

    // adjacency ram
    logic               mat_we, mat_re;
    logic [VW-1:0]      mat_waddr, mat_raddr;
    logic [NV-1:0]      mat_wdata, mat_rdata, mat_row;

    // walk and circuit stacks
    logic               ws_we, ws_re, cs_we, cs_re;
    logic [SAW-1:0]     ws_waddr, ws_raddr, cs_waddr, cs_raddr;
    logic [VW-1:0]      ws_wdata, ws_rdata, cs_wdata, cs_rdata;

    // row scanner
    logic               scan_start;
    t_scan_rsp          scan_rsp;
    logic [VW-1:0]      scan_idx;

    // index conversions and derived values
    logic [VW+VTX_W-1:0] w_a_ext, w_b_ext;
    logic [VW-1:0]       w_a_idx, w_b_idx;
    logic                w_a_ok, w_b_ok;
    logic [VW+VTX_W-1:0] w_cs_ext;
    logic [VTX_W-1:0]    w_cs_vtx;
    logic [STW-1:0]      w_ct_inc, w_ct_dec, w_wt_m2;
    logic [STW+CNT_W-1:0] w_ct_wide, w_ct_inc_wide;
    logic [NV-1:0]       oh_a, oh_b, oh_cur, oh_idx;
    logic                w_walk_room, w_circ_room;

    assign w_a_ext  = {{VW{1'b0}}, r_a_in};
    assign w_b_ext  = {{VW{1'b0}}, r_b_in};
    assign w_a_idx  = w_a_ext[VW-1:0];
    assign w_b_idx  = w_b_ext[VW-1:0];
    assign w_a_ok   = w_a_ext < (VW+VTX_W)'(NV);
    assign w_b_ok   = w_b_ext < (VW+VTX_W)'(NV);
    assign w_cs_ext = {{VTX_W{1'b0}}, cs_rdata};
    assign w_cs_vtx = w_cs_ext[VTX_W-1:0];

    assign w_ct_inc      = r_circ_top + STW'(1);
    assign w_ct_dec      = r_circ_top - STW'(1);
    assign w_wt_m2       = r_walk_top - STW'(2);
    assign w_ct_wide     = {{CNT_W{1'b0}}, r_circ_top};
    assign w_ct_inc_wide = {{CNT_W{1'b0}}, w_ct_inc};
    assign w_walk_room   = r_walk_top < STW'(STACK_DEPTH);
    assign w_circ_room   = r_circ_top < STW'(STACK_DEPTH);

    assign oh_a   = {{(NV-1){1'b0}}, 1'b1} << w_a_idx;
    assign oh_b   = {{(NV-1){1'b0}}, 1'b1} << w_b_idx;
    assign oh_cur = {{(NV-1){1'b0}}, 1'b1} << r_cur;
    assign oh_idx = {{(NV-1){1'b0}}, 1'b1} << scan_idx;

    // a row never written since reset or clear reads as empty
    assign mat_row = mat_rdata & {NV{r_rd_vld}};

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.vertex = r_out_vertex;
    assign o_rsp.count  = r_out_count;

    ecw_ram #(.WIDTH(NV), .DEPTH(NV)) u_adj (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (mat_wdata),
        .i_re    (mat_re),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    ecw_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_walk_stack (
        .i_clk   (i_clk),
        .i_we    (ws_we),
        .i_waddr (ws_waddr),
        .i_wdata (ws_wdata),
        .i_re    (ws_re),
        .i_raddr (ws_raddr),
        .o_rdata (ws_rdata)
    );

    ecw_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_circ_stack (
        .i_clk   (i_clk),
        .i_we    (cs_we),
        .i_waddr (cs_waddr),
        .i_wdata (cs_wdata),
        .i_re    (cs_re),
        .i_raddr (cs_raddr),
        .o_rdata (cs_rdata)
    );

    ecw_scan #(.NV(NV)) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_row   (r_row),
        .o_rsp   (scan_rsp),
        .o_index (scan_idx)
    );

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_row_vld    = r_row_vld;
        n_rd_vld     = r_rd_vld;
        n_walk_top   = r_walk_top;
        n_circ_top   = r_circ_top;
        n_edges      = r_edges;
        n_out_valid  = r_out_valid;
        n_a_in       = r_a_in;
        n_b_in       = r_b_in;
        n_cur        = r_cur;
        n_nbr        = r_nbr;
        n_row        = r_row;
        n_res_status = r_res_status;
        n_res_vertex = r_res_vertex;
        n_res_count  = r_res_count;
        n_out_status = r_out_status;
        n_out_vertex = r_out_vertex;
        n_out_count  = r_out_count;

        mat_we    = 1'b0;
        mat_waddr = r_cur;
        mat_wdata = r_row;
        mat_re    = 1'b0;
        mat_raddr = r_cur;
        ws_we     = 1'b0;
        ws_waddr  = r_walk_top[SAW-1:0];
        ws_wdata  = r_nbr;
        ws_re     = 1'b0;
        ws_raddr  = w_wt_m2[SAW-1:0];
        cs_we     = 1'b0;
        cs_waddr  = r_circ_top[SAW-1:0];
        cs_wdata  = r_cur;
        cs_re     = 1'b0;
        cs_raddr  = w_ct_dec[SAW-1:0];
        scan_start = 1'b0;

        // response register drains on a transfer
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_kind  = i_cmd.kind;
                    n_a_in  = i_cmd.vertex_a;
                    n_b_in  = i_cmd.vertex_b;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_res_status = ST_REJECTED;
                n_res_vertex = '0;
                n_res_count  = r_edges;
                n_state      = S_EMIT;
                case (r_kind)
                    KIND_ADD: begin
                        if (r_a_in != r_b_in && w_a_ok && w_b_ok &&
                            r_edges < CNT_W'(EDGE_LIMIT)) begin
                            mat_re    = 1'b1;
                            mat_raddr = w_a_idx;
                            n_state   = S_ADD_CHK;
                        end
                    end
                    KIND_CLEAR: begin
                        n_row_vld    = '0;
                        n_walk_top   = '0;
                        n_circ_top   = '0;
                        n_edges      = '0;
                        n_res_status = ST_CLEARED;
                        n_res_count  = '0;
                    end
                    KIND_BUILD: begin
                        // old circuit is dropped, start vertex seeds the walk
                        if (w_a_ok) begin
                            n_circ_top = '0;
                            ws_we      = 1'b1;
                            ws_waddr   = '0;
                            ws_wdata   = w_a_idx;
                            n_walk_top = STW'(1);
                            n_cur      = w_a_idx;
                            n_state    = S_B_READ;
                        end
                    end
                    KIND_POP: begin
                        if (r_circ_top == '0) begin
                            n_res_status = ST_EXHAUSTED;
                            n_res_count  = '0;
                        end else begin
                            n_circ_top = w_ct_dec;
                            cs_re      = 1'b1;
                            n_state    = S_POP_WAIT;
                        end
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end

            S_ADD_CHK: begin
                if (mat_row[w_b_idx]) begin
                    // duplicate edge
                    n_res_status = ST_REJECTED;
                    n_res_count  = r_edges;
                    n_state      = S_EMIT;
                end else begin
                    mat_we    = 1'b1;
                    mat_waddr = w_a_idx;
                    mat_wdata = mat_row | oh_b;
                    mat_re    = 1'b1;
                    mat_raddr = w_b_idx;
                    n_state   = S_ADD_B;
                end
            end

            S_ADD_B: begin
                mat_we       = 1'b1;
                mat_waddr    = w_b_idx;
                mat_wdata    = mat_row | oh_a;
                n_edges      = r_edges + CNT_W'(1);
                n_res_status = ST_ADDED;
                n_res_count  = r_edges + CNT_W'(1);
                n_state      = S_EMIT;
            end

            S_B_READ: begin
                mat_re    = 1'b1;
                mat_raddr = r_cur;
                n_state   = S_B_LOAD;
            end

            S_B_LOAD: begin
                n_row      = mat_row;
                scan_start = 1'b1;
                n_state    = S_B_SCAN;
            end

            S_B_SCAN: begin
                if (scan_rsp.done) begin
                    if (scan_rsp.found && w_walk_room) begin
                        // drop edge cur->nbr and fetch the neighbour's row
                        n_nbr     = scan_idx;
                        mat_we    = 1'b1;
                        mat_waddr = r_cur;
                        mat_wdata = r_row & ~oh_idx;
                        mat_re    = 1'b1;
                        mat_raddr = scan_idx;
                        n_state   = S_B_DEL;
                    end else begin
                        // vertex finished: retire it onto the circuit
                        n_walk_top = r_walk_top - STW'(1);
                        if (w_circ_room) begin
                            cs_we      = 1'b1;
                            n_circ_top = w_ct_inc;
                        end
                        if (r_walk_top > STW'(1)) begin
                            ws_re   = 1'b1;
                            n_state = S_B_POP_WAIT;
                        end else begin
                            n_res_status = ST_BUILT;
                            n_res_vertex = '0;
                            n_res_count  = w_circ_room ? w_ct_inc_wide[CNT_W-1:0]
                                                       : w_ct_wide[CNT_W-1:0];
                            n_state      = S_EMIT;
                        end
                    end
                end
            end

            S_B_DEL: begin
                // drop the reverse edge, push the neighbour and scan its row
                mat_we     = 1'b1;
                mat_waddr  = r_nbr;
                mat_wdata  = mat_row & ~oh_cur;
                n_row      = mat_row & ~oh_cur;
                if (r_edges != '0) begin
                    n_edges = r_edges - CNT_W'(1);
                end
                ws_we      = 1'b1;
                n_walk_top = r_walk_top + STW'(1);
                n_cur      = r_nbr;
                scan_start = 1'b1;
                n_state    = S_B_SCAN;
            end

            S_B_POP_WAIT: begin
                n_cur   = ws_rdata;
                n_state = S_B_READ;
            end

            S_POP_WAIT: begin
                n_res_status = ST_VERTEX;
                n_res_vertex = w_cs_vtx;
                n_res_count  = w_ct_wide[CNT_W-1:0];
                n_state      = S_EMIT;
            end

            S_EMIT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_vertex = r_res_vertex;
                    n_out_count  = r_res_count;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (mat_we) begin
            n_row_vld[mat_waddr] = 1'b1;
        end
        if (mat_re) begin
            n_rd_vld = r_row_vld[mat_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= KIND_ADD;
            r_row_vld   <= '0;
            r_rd_vld    <= 1'b0;
            r_walk_top  <= '0;
            r_circ_top  <= '0;
            r_edges     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_row_vld   <= n_row_vld;
            r_rd_vld    <= n_rd_vld;
            r_walk_top  <= n_walk_top;
            r_circ_top  <= n_circ_top;
            r_edges     <= n_edges;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_a_in       <= n_a_in;
        r_b_in       <= n_b_in;
        r_cur        <= n_cur;
        r_nbr        <= n_nbr;
        r_row        <= n_row;
        r_res_status <= n_res_status;
        r_res_vertex <= n_res_vertex;
        r_res_count  <= n_res_count;
        r_out_status <= n_out_status;
        r_out_vertex <= n_out_vertex;
        r_out_count  <= n_out_count;
    end
endmodule

[hdl/ecw_checker.sv]
// port-level checker for the euler circuit walker, bound to the top level
module ecw_checker import ecw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [VTX_W-1:0]    i_vertex,
    input  logic [CNT_W-1:0]    i_count
);
    // one command at a time: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command taken while previous one still in work");

    // a response appears only after some command was taken
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !i_in_ready || $past(!i_in_ready))
        else $error("response without a command in work");

    // vertex is only nonzero on a vertex response
    a_vertex_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_VERTEX |-> i_vertex == '0)
        else $error("nonzero vertex on a non-vertex response");

    // clear and exhausted responses carry a zero count
    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_CLEARED || i_status == ST_EXHAUSTED)
        |-> i_count == '0)
        else $error("nonzero count on clear or exhausted response");

    // stalled response holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
        i_out_valid && $stable(i_status) && $stable(i_vertex) && $stable(i_count))
        else $error("stalled response changed");
endmodule

bind euler_circuit_walker ecw_checker u_ecw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_vertex    (o_rsp.vertex),
    .i_count     (o_rsp.count)
);

[verif/euler_circuit_walker_tb.sv]
// self-checking testbench of the euler circuit walker: directed table, then random episodes
module euler_circuit_walker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ecw_pkg::*;

    localparam int MAX_V       = DEF_MAX_VERTICES;
    localparam int STACK_SLOTS = DEF_STACK_DEPTH;
    localparam int EDGE_LIMIT  = (STACK_SLOTS - 1 < EDGE_CAP) ? STACK_SLOTS - 1 : EDGE_CAP;
    localparam int ITEM_TARGET = 1750;
    // cycles without any transfer before the run is declared hung; a build over a
    // complete graph at 8 bits per scan cycle stays well below this
    localparam int STALL_LIMIT = 200000;
    localparam int N_DIRECTED  = 26;
    localparam int EXP_SLOTS   = 16;
    localparam int RING_MAX    = 10;

    typedef struct packed {
        t_status               status;
        logic [VTX_W-1:0]      vertex;
        logic [CNT_W-1:0]      count;
    } t_rsp_word;

    typedef struct {
        t_kind                 kind;
        logic [VTX_W-1:0]      a;
        logic [VTX_W-1:0]      b;
        bit                    fixed;
        t_rsp_word             rsp;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ecw_cmd_if cmd ();
    ecw_rsp_if rsp ();

    euler_circuit_walker u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_rsp   (rsp)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: graph, circuit stack and edge total as the block
    // should hold them after every accepted command
    // ------------------------------------------------------------------
    logic [MAX_V-1:0]   adj_rows    [MAX_V];
    logic [VTX_W-1:0]   circ_stack  [STACK_SLOTS];
    logic [VTX_W-1:0]   walk_trail  [STACK_SLOTS];
    int                 circ_top    = 0;
    int                 edge_total  = 0;

    // expected responses in order; head and tail only ever count up
    t_rsp_word          exp_fifo    [EXP_SLOTS];
    int                 exp_head    = 0;
    int                 exp_tail    = 0;
    int                 error_count = 0;
    int                 items_sent  = 0;
    int                 rsp_seen    = 0;
    int                 burst_left  = 8;

    // one command through the walker; returns the response it must give
    function automatic t_rsp_word euler_step(t_kind k, int a, int b);
        t_rsp_word r;
        int   depth;
        int   v;
        int   x;
        r.status = ST_REJECTED;
        r.vertex = '0;
        r.count  = edge_total[CNT_W-1:0];
        case (k)
            KIND_ADD: begin
                // self-loop, duplicate, out-of-range endpoint or full store: rejected
                if (a != b && a < MAX_V && b < MAX_V && !adj_rows[a][b] &&
                    edge_total < EDGE_LIMIT) begin
                    adj_rows[a][b] = 1'b1;
                    adj_rows[b][a] = 1'b1;
                    edge_total++;
                    r.status = ST_ADDED;
                end
                r.count = edge_total[CNT_W-1:0];
            end
            KIND_CLEAR: begin
                for (int i = 0; i < MAX_V; i++) adj_rows[i] = '0;
                edge_total = 0;
                circ_top   = 0;
                r.status   = ST_CLEARED;
                r.count    = '0;
            end
            KIND_BUILD: begin
                if (a < MAX_V) begin
                    // hierholzer walk, always taking the lowest remaining neighbour
                    circ_top      = 0;
                    depth         = 1;
                    walk_trail[0] = VTX_W'(a);
                    while (depth > 0) begin
                        v = walk_trail[depth-1];
                        x = -1;
                        for (int i = MAX_V - 1; i >= 0; i--)
                            if (adj_rows[v][i]) x = i;
                        if (x >= 0 && depth < STACK_SLOTS) begin
                            adj_rows[v][x] = 1'b0;
                            adj_rows[x][v] = 1'b0;
                            if (edge_total > 0) edge_total--;
                            walk_trail[depth] = VTX_W'(x);
                            depth++;
                        end else begin
                            // dead end: vertex retires onto the circuit
                            depth--;
                            if (circ_top < STACK_SLOTS) begin
                                circ_stack[circ_top] = VTX_W'(v);
                                circ_top++;
                            end
                        end
                    end
                    r.status = ST_BUILT;
                    r.count  = circ_top[CNT_W-1:0];
                end
            end
            default: begin
                if (circ_top == 0) begin
                    r.status = ST_EXHAUSTED;
                    r.count  = '0;
                end else begin
                    circ_top--;
                    r.vertex = circ_stack[circ_top];
                    r.status = ST_VERTEX;
                    r.count  = circ_top[CNT_W-1:0];
                end
            end
        endcase
        return r;
    endfunction

    function automatic int rand_v();
        return $urandom_range(0, MAX_V - 1);
    endfunction

    // drive one command, wait for its transfer, then log its expected response;
    // a fixed response replaces the predicted one but the predictor still steps
    task automatic issue(t_kind k, int a, int b, bit fixed = 1'b0,
                         t_rsp_word fixed_rsp = '0);
        t_rsp_word predicted;
        cmd.valid    <= 1'b1;
        cmd.kind     <= k;
        cmd.vertex_a <= VTX_W'(a);
        cmd.vertex_b <= VTX_W'(b);
        do @(posedge i_clk); while (cmd.ready !== 1'b1);
        predicted = euler_step(k, a, b);
        exp_fifo[exp_tail % EXP_SLOTS] = fixed ? fixed_rsp : predicted;
        exp_tail++;
        items_sent++;
        // sender works in bursts; between bursts valid drops for a random gap
        burst_left--;
        if (burst_left <= 0) begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // hold the sender until every outstanding response has come back
    task automatic drain_responses();
        cmd.valid <= 1'b0;
        while (exp_tail != exp_head) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // directed table: reset state, field extremes, every command kind,
    // self-loops, reversed duplicates, lone start vertex, add while a
    // circuit is pending, non-eulerian build, clear with circuit pending
    // ------------------------------------------------------------------
    t_stim_row directed [N_DIRECTED];

    initial begin
        directed = '{
            '{KIND_POP,   6'd0,  6'd0,  1'b1, '{ST_EXHAUSTED, 6'd0,  11'd0}},
            '{KIND_ADD,   6'd0,  6'd0,  1'b1, '{ST_REJECTED,  6'd0,  11'd0}},
            '{KIND_ADD,   6'd63, 6'd63, 1'b1, '{ST_REJECTED,  6'd0,  11'd0}},
            '{KIND_BUILD, 6'd63, 6'd0,  1'b1, '{ST_BUILT,     6'd0,  11'd1}},
            '{KIND_POP,   6'd63, 6'd63, 1'b1, '{ST_VERTEX,    6'd63, 11'd0}},
            '{KIND_POP,   6'd0,  6'd63, 1'b1, '{ST_EXHAUSTED, 6'd0,  11'd0}},
            '{KIND_ADD,   6'd0,  6'd63, 1'b1, '{ST_ADDED,     6'd0,  11'd1}},
            '{KIND_ADD,   6'd63, 6'd0,  1'b1, '{ST_REJECTED,  6'd0,  11'd1}},
            '{KIND_ADD,   6'd0,  6'd1,  1'b0, '0},
            '{KIND_ADD,   6'd1,  6'd63, 1'b0, '0},
            '{KIND_ADD,   6'd5,  6'd6,  1'b0, '0},
            '{KIND_BUILD, 6'd63, 6'd42, 1'b0, '0},
            '{KIND_POP,   6'd21, 6'd42, 1'b0, '0},
            '{KIND_ADD,   6'd7,  6'd8,  1'b0, '0},
            '{KIND_POP,   6'd0,  6'd0,  1'b0, '0},
            '{KIND_POP,   6'd0,  6'd0,  1'b0, '0},
            '{KIND_POP,   6'd0,  6'd0,  1'b0, '0},
            '{KIND_POP,   6'd0,  6'd0,  1'b0, '0},
            '{KIND_CLEAR, 6'd63, 6'd63, 1'b1, '{ST_CLEARED,   6'd0,  11'd0}},
            '{KIND_BUILD, 6'd5,  6'd0,  1'b1, '{ST_BUILT,     6'd0,  11'd1}},
            '{KIND_ADD,   6'd62, 6'd61, 1'b0, '0},
            '{KIND_ADD,   6'd61, 6'd60, 1'b0, '0},
            '{KIND_ADD,   6'd62, 6'd59, 1'b0, '0},
            '{KIND_BUILD, 6'd62, 6'd0,  1'b0, '0},
            '{KIND_CLEAR, 6'd0,  6'd0,  1'b1, '{ST_CLEARED,   6'd0,  11'd0}},
            '{KIND_POP,   6'd0,  6'd0,  1'b1, '{ST_EXHAUSTED, 6'd0,  11'd0}}
        };
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int               episode;
        int               n_loops;
        int               len;
        int               span;
        int               lo;
        int               start;
        int               pick;
        int               pops;
        int               order;
        logic [MAX_V-1:0] used;
        int               ring [RING_MAX];
        int               ring_n;

        for (int i = 0; i < MAX_V; i++) adj_rows[i] = '0;
        cmd.valid    <= 1'b0;
        cmd.kind     <= KIND_ADD;
        cmd.vertex_a <= '0;
        cmd.vertex_b <= '0;
        i_rst_n      <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n      <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            issue(directed[i].kind, directed[i].a, directed[i].b,
                  directed[i].fixed, directed[i].rsp);
        drain_responses();

        episode = 0;
        while (items_sent < N_DIRECTED + ITEM_TARGET) begin
            if (episode == 3) begin
                // complete graph of odd order: every degree even, long circuit
                order = 17;
                lo    = $urandom_range(0, MAX_V - order);
                issue(KIND_CLEAR, rand_v(), rand_v());
                for (int i = 0; i < order; i++)
                    for (int j = i + 1; j < order; j++)
                        if ($urandom_range(0, 1) == 0) issue(KIND_ADD, lo + i, lo + j);
                        else                            issue(KIND_ADD, lo + j, lo + i);
                issue(KIND_BUILD, lo + $urandom_range(0, order - 1), rand_v());
                pops = circ_top + 1;
                repeat (pops) issue(KIND_POP, rand_v(), rand_v());
            end else if ($urandom_range(0, 9) < 7) begin
                // well-formed: union of cycles over a shared vertex window, then
                // build and pop; rejected re-adds make some graphs non-eulerian
                if ($urandom_range(0, 3) != 0) issue(KIND_CLEAR, rand_v(), rand_v());
                n_loops = $urandom_range(1, 4);
                span    = ($urandom_range(0, 1) == 0) ? $urandom_range(RING_MAX, 16) : MAX_V;
                lo      = $urandom_range(0, MAX_V - span);
                start   = -1;
                for (int c = 0; c < n_loops; c++) begin
                    len    = $urandom_range(3, RING_MAX);
                    used   = '0;
                    ring_n = 0;
                    while (ring_n < len) begin
                        pick = lo + $urandom_range(0, span - 1);
                        if (!used[pick]) begin
                            used[pick]   = 1'b1;
                            ring[ring_n] = pick;
                            ring_n++;
                        end
                    end
                    if (start < 0) start = ring[0];
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(0, 1) == 0) issue(KIND_ADD, ring[i], ring[(i+1)%len]);
                        else                            issue(KIND_ADD, ring[(i+1)%len], ring[i]);
                        case ($urandom_range(0, 15))
                            0:       issue(KIND_ADD, ring[i], ring[i]);
                            1:       issue(KIND_ADD, ring[(i+1)%len], ring[i]);
                            2:       issue(KIND_POP, rand_v(), rand_v());
                            default: ;
                        endcase
                    end
                end
                if ($urandom_range(0, 5) == 0) start = rand_v();
                issue(KIND_BUILD, start, rand_v());
                // mostly read out the whole circuit and run past its end
                pops = ($urandom_range(0, 4) == 0) ? $urandom_range(0, circ_top)
                                                    : circ_top + $urandom_range(0, 2);
                repeat (pops) issue(KIND_POP, rand_v(), rand_v());
            end else begin
                // noise: any kind, endpoints often packed into a narrow window
                repeat ($urandom_range(10, 30)) begin
                    if ($urandom_range(0, 1) == 0)
                        issue(t_kind'(KIND_W'($urandom_range(0, 3))),
                              $urandom_range(0, 7), $urandom_range(0, 7));
                    else
                        issue(t_kind'(KIND_W'($urandom_range(0, 3))), rand_v(), rand_v());
                end
            end
            if ($urandom_range(0, 3) == 0) drain_responses();
            episode++;
        end

        drain_responses();
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("euler_circuit_walker_tb: PASS");
        else
            $display("euler_circuit_walker_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern is redrawn periodically among always ready,
    // random stalls and long periodic stalls
    // ------------------------------------------------------------------
    initial begin
        int stall_phase;
        int stall_mode;
        stall_phase = 0;
        stall_mode  = 0;
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            stall_phase++;
            if (stall_phase % 300 == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0:       rsp.ready <= 1'b1;
                1:       rsp.ready <= ($urandom_range(0, 3) != 0);
                default: rsp.ready <= ((stall_phase % 13) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // response check against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp_word want;
        if (i_rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (exp_tail == exp_head) begin
                error_count++;
                $display("%0t: unexpected response: status=%0d vertex=%0d count=%0d",
                         $time, rsp.status, rsp.vertex, rsp.count);
            end else begin
                want = exp_fifo[exp_head % EXP_SLOTS];
                exp_head++;
                if (rsp.status !== want.status || rsp.vertex !== want.vertex ||
                    rsp.count !== want.count) begin
                    error_count++;
                    $display({"%0t: response %0d mismatch: expected status=%s vertex=%0d",
                              " count=%0d, actual status=%0d vertex=%0d count=%0d"},
                             $time, rsp_seen, want.status.name(), want.vertex,
                             want.count, rsp.status, rsp.vertex, rsp.count);
                end
            end
            rsp_seen++;
        end
    end

    // watchdog: any transfer on either side restarts the count
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd.valid === 1'b1 && cmd.ready === 1'b1) ||
                (rsp.valid === 1'b1 && rsp.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("euler_circuit_walker_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/ecw_pkg.sv
hdl/ecw_if.sv
hdl/ecw_ram.sv
hdl/ecw_scan.sv
hdl/euler_circuit_walker.sv
hdl/ecw_checker.sv
verif/euler_circuit_walker_tb.sv
